// ===== hdl/sbfr_pkg.sv =====
package sbfr_pkg;

	// frame layout
	localparam int FRAME_BYTES_DEF = 25;
	localparam logic [7:0] START_BYTE = 8'h0F;
	localparam int POS_W = 6;

	// only bytes 1 to 9 carry channel bits
	localparam int IDX_W = 4;
	localparam logic [IDX_W-1:0] FIRST_CH_BYTE = 4'd1;
	localparam logic [IDX_W-1:0] LAST_CH_BYTE = 4'd9;
	localparam int CH_W = 11;

	// command queue between front and back
	localparam int CMD_DEPTH_DEF = 4;

	typedef enum logic {
		CMD_STORE,
		CMD_EMIT
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [IDX_W-1:0] idx;
		logic [7:0] data;
	} cmd_t;

	typedef struct packed {
		logic in_frame;
		logic [POS_W-1:0] pos;
	} front_stat_t;

endpackage

// ===== hdl/sbfr_front.sv =====
module sbfr_front #(
	parameter int FRAME_BYTES = sbfr_pkg::FRAME_BYTES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] rx_byte,
	input  logic push,
	output logic full,
	input  logic cmd_full,
	output logic cmd_push,
	output sbfr_pkg::cmd_t cmd,
	output sbfr_pkg::front_stat_t stat
);

	localparam logic [sbfr_pkg::POS_W-1:0] LAST = sbfr_pkg::POS_W'(FRAME_BYTES - 1);

	logic in_frame_q;
	logic [sbfr_pkg::POS_W-1:0] pos_q;
	logic accept;
	logic in_frame_d;
	logic [sbfr_pkg::POS_W-1:0] pos_d;
	logic ch_pos;

	assign full = cmd_full;
	assign accept = push && !cmd_full;
	assign ch_pos = (pos_q >= sbfr_pkg::POS_W'(sbfr_pkg::FIRST_CH_BYTE))
		&& (pos_q <= sbfr_pkg::POS_W'(sbfr_pkg::LAST_CH_BYTE));

	// classify the byte against frame position
	always_comb begin
		in_frame_d = in_frame_q;
		pos_d = pos_q;
		cmd_push = 1'b0;
		cmd.kind = sbfr_pkg::CMD_STORE;
		cmd.idx = pos_q[sbfr_pkg::IDX_W-1:0];
		cmd.data = rx_byte;
		priority if (!in_frame_q && rx_byte == sbfr_pkg::START_BYTE) begin
			in_frame_d = 1'b1;
			pos_d = sbfr_pkg::POS_W'(1);
		end else if (in_frame_q && pos_q < LAST) begin
			pos_d = pos_q + sbfr_pkg::POS_W'(1);
			cmd_push = accept && ch_pos;
		end else if (in_frame_q && pos_q == LAST) begin
			// end byte: value dropped, frame decoded
			in_frame_d = 1'b0;
			pos_d = '0;
			cmd.kind = sbfr_pkg::CMD_EMIT;
			cmd_push = accept;
		end else begin
			in_frame_d = 1'b0;
			pos_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_frame_q <= 1'b0;
			pos_q <= '0;
		end else if (accept) begin
			in_frame_q <= in_frame_d;
			pos_q <= pos_d;
		end
	end

	assign stat.in_frame = in_frame_q;
	assign stat.pos = pos_q;

endmodule

// ===== hdl/sbfr_cmd_fifo.sv =====
module sbfr_cmd_fifo #(
	parameter int DEPTH = sbfr_pkg::CMD_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  sbfr_pkg::cmd_t wr_data,
	output logic full,
	input  logic rd,
	output sbfr_pkg::cmd_t rd_data,
	output logic empty
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

	sbfr_pkg::cmd_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr;
	logic do_rd;

	assign full = (count_q == CNT_W'(DEPTH));
	assign empty = (count_q == '0);
	assign do_wr = wr && !full;
	assign do_rd = rd && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/sbfr_back.sv =====
module sbfr_back (
	input  logic clk,
	input  logic arst_n,
	input  sbfr_pkg::cmd_t cmd,
	input  logic cmd_empty,
	output logic cmd_pop,
	output logic [sbfr_pkg::CH_W-1:0] ch1,
	output logic [sbfr_pkg::CH_W-1:0] ch2,
	output logic [sbfr_pkg::CH_W-1:0] ch3,
	output logic [sbfr_pkg::CH_W-1:0] ch4,
	output logic [sbfr_pkg::CH_W-1:0] ch5,
	output logic [sbfr_pkg::CH_W-1:0] ch6,
	output logic empty,
	input  logic pop
);

	logic [7:0] byte_q [sbfr_pkg::FIRST_CH_BYTE:sbfr_pkg::LAST_CH_BYTE];
	logic out_valid_q;
	logic out_free;
	logic do_store;
	logic do_emit;

	assign out_free = !out_valid_q || pop;
	assign cmd_pop = !cmd_empty && (cmd.kind == sbfr_pkg::CMD_STORE || out_free);
	assign do_store = cmd_pop && cmd.kind == sbfr_pkg::CMD_STORE;
	assign do_emit = cmd_pop && cmd.kind == sbfr_pkg::CMD_EMIT;
	assign empty = !out_valid_q;

	always_ff @(posedge clk) begin
		if (do_store) begin
			byte_q[cmd.idx] <= cmd.data;
		end
		// unpack six little-endian 11-bit fields
		if (do_emit) begin
			ch1 <= {byte_q[2][2:0], byte_q[1]};
			ch2 <= {byte_q[3][5:0], byte_q[2][7:3]};
			ch3 <= {byte_q[5][0], byte_q[4], byte_q[3][7:6]};
			ch4 <= {byte_q[6][3:0], byte_q[5][7:1]};
			ch5 <= {byte_q[7][6:0], byte_q[6][7:4]};
			ch6 <= {byte_q[9][1:0], byte_q[8], byte_q[7][7]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (do_emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// ===== hdl/sbfr_frame_receiver_six_channel.sv =====
// a frame's end byte request, once taken, queues an emit command; the channel set is
// registered onto the result ports once nothing older is queued and the result is free
// throughput: one byte request per cycle; byte requests keep flowing while a result waits
// until the command queue fills (CMD_DEPTH entries)
// reset: arst_n clears frame hunting state, queue pointers and the result valid flag
// at once; no clearing pass, the byte store is written by every frame before use
module sbus_frame_receiver_six_channel #(
	parameter int FRAME_BYTES = sbfr_pkg::FRAME_BYTES_DEF,
	parameter int CMD_DEPTH = sbfr_pkg::CMD_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] rx_byte,
	input  logic push,
	output logic full,
	output logic [sbfr_pkg::CH_W-1:0] ch1,
	output logic [sbfr_pkg::CH_W-1:0] ch2,
	output logic [sbfr_pkg::CH_W-1:0] ch3,
	output logic [sbfr_pkg::CH_W-1:0] ch4,
	output logic [sbfr_pkg::CH_W-1:0] ch5,
	output logic [sbfr_pkg::CH_W-1:0] ch6,
	output logic empty,
	input  logic pop
);

	localparam logic [sbfr_pkg::POS_W-1:0] LAST = sbfr_pkg::POS_W'(FRAME_BYTES - 1);

	// front to queue
	sbfr_pkg::cmd_t cmd_in;
	logic cmd_push;
	logic cmd_full;
	// queue to back
	sbfr_pkg::cmd_t cmd_out;
	logic cmd_pop;
	logic cmd_empty;
	sbfr_pkg::front_stat_t front_stat;

	// front: tracks start byte and position, sends store and emit commands
	sbfr_front #(
		.FRAME_BYTES(FRAME_BYTES)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.rx_byte(rx_byte),
		.push(push),
		.full(full),
		.cmd_full(cmd_full),
		.cmd_push(cmd_push),
		.cmd(cmd_in),
		.stat(front_stat)
	);

	// short queue decoupling byte intake from channel unpacking
	sbfr_cmd_fifo #(
		.DEPTH(CMD_DEPTH)
	) u_cmd_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr(cmd_push),
		.wr_data(cmd_in),
		.full(cmd_full),
		.rd(cmd_pop),
		.rd_data(cmd_out),
		.empty(cmd_empty)
	);

	// back: holds bytes 1 to 9, unpacks channels into the result register
	sbfr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_out),
		.cmd_empty(cmd_empty),
		.cmd_pop(cmd_pop),
		.ch1(ch1),
		.ch2(ch2),
		.ch3(ch3),
		.ch4(ch4),
		.ch5(ch5),
		.ch6(ch6),
		.empty(empty),
		.pop(pop)
	);

	// hunting always means position zero
	a_hunt_pos: assert property (@(posedge clk) disable iff (!arst_n)
		!front_stat.in_frame |-> front_stat.pos == '0)
		else $error("position nonzero while hunting");

	// position never runs past the end byte
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		front_stat.pos <= LAST)
		else $error("position past end byte");

	// front never writes a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !cmd_full)
		else $error("command queue overflow");

	// back never reads an empty queue
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> !cmd_empty)
		else $error("command queue underflow");

endmodule

// ===== sim/channel_checker.sv =====
`timescale 1ns / 100ps

module channel_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic [7:0] rx_byte,
	input  logic push,
	input  logic full,
	input  logic [sbfr_pkg::CH_W-1:0] ch1,
	input  logic [sbfr_pkg::CH_W-1:0] ch2,
	input  logic [sbfr_pkg::CH_W-1:0] ch3,
	input  logic [sbfr_pkg::CH_W-1:0] ch4,
	input  logic [sbfr_pkg::CH_W-1:0] ch5,
	input  logic [sbfr_pkg::CH_W-1:0] ch6,
	input  logic empty,
	input  logic pop,
	output int errors,
	output int outstanding
);

	localparam int END_POS = sbfr_pkg::FRAME_BYTES_DEF - 1;

	typedef struct packed {
		logic [sbfr_pkg::CH_W-1:0] c1;
		logic [sbfr_pkg::CH_W-1:0] c2;
		logic [sbfr_pkg::CH_W-1:0] c3;
		logic [sbfr_pkg::CH_W-1:0] c4;
		logic [sbfr_pkg::CH_W-1:0] c5;
		logic [sbfr_pkg::CH_W-1:0] c6;
	} channel_set_t;

	logic in_frame;
	logic [sbfr_pkg::POS_W-1:0] byte_pos;
	logic [7:0] bytes_held [sbfr_pkg::FRAME_BYTES_DEF];
	channel_set_t channels_due [$];
	int fail_count;

	// bytes 1 to 9 form one little-endian bit stream, 11 bits per channel
	function automatic channel_set_t unpack_channels();
		logic [71:0] stream;
		channel_set_t cs;
		stream = {bytes_held[9], bytes_held[8], bytes_held[7], bytes_held[6],
			bytes_held[5], bytes_held[4], bytes_held[3], bytes_held[2], bytes_held[1]};
		cs.c1 = stream[10:0];
		cs.c2 = stream[21:11];
		cs.c3 = stream[32:22];
		cs.c4 = stream[43:33];
		cs.c5 = stream[54:44];
		cs.c6 = stream[65:55];
		return cs;
	endfunction

	task automatic check_field(input string name, input logic [sbfr_pkg::CH_W-1:0] want,
			input logic [sbfr_pkg::CH_W-1:0] got);
		if (got !== want) begin
			$error("%s expected %0d actual %0d", name, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		channel_set_t want;
		if (!arst_n) begin
			in_frame = 1'b0;
			byte_pos = '0;
			channels_due.delete();
			fail_count = 0;
		end else begin
			if (pop && !empty) begin
				if (channels_due.size() == 0) begin
					$error("unexpected result: ch1 %0d ch2 %0d ch3 %0d ch4 %0d ch5 %0d ch6 %0d",
						ch1, ch2, ch3, ch4, ch5, ch6);
					fail_count++;
				end else begin
					want = channels_due.pop_front();
					check_field("ch1", want.c1, ch1);
					check_field("ch2", want.c2, ch2);
					check_field("ch3", want.c3, ch3);
					check_field("ch4", want.c4, ch4);
					check_field("ch5", want.c5, ch5);
					check_field("ch6", want.c6, ch6);
				end
			end
			if (push && !full) begin
				if (!in_frame) begin
					// hunting: only a start byte opens a frame
					if (rx_byte == sbfr_pkg::START_BYTE) begin
						in_frame = 1'b1;
						bytes_held[0] = rx_byte;
						byte_pos = sbfr_pkg::POS_W'(1);
					end else begin
						byte_pos = '0;
					end
				end else if (byte_pos < END_POS) begin
					bytes_held[byte_pos] = rx_byte;
					byte_pos = byte_pos + sbfr_pkg::POS_W'(1);
				end else if (byte_pos == END_POS) begin
					channels_due.push_back(unpack_channels());
					byte_pos = '0;
					in_frame = 1'b0;
				end else begin
					byte_pos = '0;
					in_frame = 1'b0;
				end
			end
		end
		errors <= fail_count;
		outstanding <= channels_due.size();
	end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

	// run length: random byte requests stop after this many in total
	localparam int ITEMS = 850;
	// from here on neither side idles
	localparam int TAIL_START = 700;
	localparam int CYCLE_LIMIT = 300000;
	// settle time at the end, after every channel set has been read out
	localparam int SETTLE_CYCLES = 8;

	// how the 23 data bytes and the end byte of a frame are filled
	typedef enum {
		FILL_RANDOM,
		FILL_ONES,
		FILL_ZEROS,
		FILL_STARTS
	} fill_t;

	logic clk;
	logic arst_n;
	logic [7:0] rx_byte;
	logic push;
	logic full;
	logic [sbfr_pkg::CH_W-1:0] ch1, ch2, ch3, ch4, ch5, ch6;
	logic empty;
	logic pop;

	int errors;
	int outstanding;
	int sent;
	int cycle_count;
	bit quiet;
	bit gaps_on;

	sbus_frame_receiver_six_channel dut (
		.clk(clk),
		.arst_n(arst_n),
		.rx_byte(rx_byte),
		.push(push),
		.full(full),
		.ch1(ch1),
		.ch2(ch2),
		.ch3(ch3),
		.ch4(ch4),
		.ch5(ch5),
		.ch6(ch6),
		.empty(empty),
		.pop(pop)
	);

	// watches both queue sides, predicts channel sets and compares them
	channel_checker u_channel_check (
		.clk(clk),
		.arst_n(arst_n),
		.rx_byte(rx_byte),
		.push(push),
		.full(full),
		.ch1(ch1),
		.ch2(ch2),
		.ch3(ch3),
		.ch4(ch4),
		.ch5(ch5),
		.ch6(ch6),
		.empty(empty),
		.pop(pop),
		.errors(errors),
		.outstanding(outstanding)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("testbench: errors");
			$finish;
		end
	end

	// one byte request: maybe an idle burst first, then hold push until the
	// block takes it (full is sampled at the rising edge)
	task automatic send_byte(input logic [7:0] value);
		int gap;
		if (!quiet && gaps_on && $urandom_range(0, 7) == 0) begin
			gap = $urandom_range(1, 5);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
				rx_byte <= 8'($urandom_range(0, 255));
			end
		end
		@(negedge clk);
		push <= 1'b1;
		rx_byte <= value;
		do @(posedge clk); while (full);
		sent++;
		if (sent >= TAIL_START)
			quiet = 1'b1;
	endtask

	// start byte, 23 data bytes, end byte
	task automatic send_frame(input fill_t fill);
		logic [7:0] value;
		send_byte(sbfr_pkg::START_BYTE);
		for (int i = 1; i < sbfr_pkg::FRAME_BYTES_DEF; i++) begin
			case (fill)
				FILL_ONES: begin
					value = 8'hFF;
				end
				FILL_ZEROS: begin
					// end byte value is never checked, give it the start code
					value = (i == sbfr_pkg::FRAME_BYTES_DEF - 1) ? sbfr_pkg::START_BYTE : 8'h00;
				end
				FILL_STARTS: begin
					// start codes inside a frame are plain data
					value = $urandom_range(0, 1) ? sbfr_pkg::START_BYTE
						: 8'($urandom_range(0, 255));
				end
				default: begin
					value = 8'($urandom_range(0, 255));
				end
			endcase
			send_byte(value);
		end
	endtask

	// result side: pop with random stall bursts, in stretches
	// that sometimes have no stalls at all
	initial begin
		int stall_left;
		int stretch;
		bit stalls_on;
		stall_left = 0;
		stretch = 0;
		stalls_on = 1'b0;
		pop = 1'b0;
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				stretch = $urandom_range(20, 80);
				stalls_on = $urandom_range(0, 2) != 0;
			end
			stretch--;
			if (stall_left > 0) begin
				stall_left--;
				pop <= 1'b0;
			end else if (!quiet && stalls_on && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 4);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// request side and verdict
	initial begin
		int burst;
		int pick;
		arst_n = 1'b0;
		push = 1'b0;
		rx_byte = 8'h00;
		quiet = 1'b0;
		gaps_on = 1'b0;
		sent = 0;
		cycle_count = 0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		// directed: noise while hunting, including neighbors of the start code
		gaps_on = 1'b1;
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h0E);
		send_byte(8'h10);
		// every channel at its maximum, then all zero with a start code as end byte
		send_frame(FILL_ONES);
		send_frame(FILL_ZEROS);
		// start codes as data
		send_frame(FILL_STARTS);

		// hold off until every channel set has been read out
		@(negedge clk);
		push <= 1'b0;
		while (outstanding != 0) @(posedge clk);

		// random: mostly whole frames with random content, some noise bursts that
		// may open a frame at a random point and shift the framing
		while (sent < ITEMS) begin
			gaps_on = $urandom_range(0, 3) != 0;
			if ($urandom_range(0, 6) == 0) begin
				burst = $urandom_range(1, 30);
				repeat (burst) send_byte(8'($urandom_range(0, 255)));
			end else begin
				pick = $urandom_range(0, 19);
				if (pick == 0)
					send_frame(FILL_ONES);
				else if (pick == 1)
					send_frame(FILL_ZEROS);
				else if (pick < 4)
					send_frame(FILL_STARTS);
				else
					send_frame(FILL_RANDOM);
			end
		end

		@(negedge clk);
		push <= 1'b0;
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && outstanding == 0)
			$display("testbench: clean");
		else
			$display("testbench: errors");
		$finish;
	end

endmodule
